// ===== hdl/knn_heap_pkg.sv =====
`default_nettype none
package knn_heap_pkg;
	localparam int DIST_W = 32;
	localparam int ITEM_W = 31;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_DRAIN = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIFT,
		ST_REPLY,
		ST_DCOPY,
		ST_DTAKE,
		ST_DSIFT,
		ST_DEMIT,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [ITEM_W-1:0] item_index;
		logic [DIST_W-1:0] distance;
	} req_t;

	typedef struct packed {
		logic              reply_kind;
		logic              accepted;
		logic [DIST_W-1:0] out_distance;
		logic [ITEM_W-1:0] out_index;
		logic              last;
	} rsp_t;
endpackage
`default_nettype wire

// ===== hdl/knn_heap_if.sv =====
`default_nettype none
interface knn_heap_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/k_nearest_max_heap.sv =====
`default_nettype none
// Channel  Dir  Payload
// req      in   command, item_index, distance
// rsp      out  reply_kind, accepted, out_distance, out_index, last
//
// Push: take the request in the idle state, then one sift level per cycle
// through the shared compare unit: up to floor(log2(K)) swaps plus one final
// compare, then present the reply. A push farther than the root skips the sift.
// Drain: copy the heap into the work array, then for each of K entries
// a take step plus up to floor(log2(K)) swaps and one final
// compare; results are stored and emitted one per cycle as the consumer
// takes them.
// Clear: one slot per cycle. Reset clears the heap at once.
// A full output register holds while rsp.ready is low; no new request
// is taken until all results of the current one are loaded into the output register.
module k_nearest_max_heap
	import knn_heap_pkg::*;
#(
	parameter int K = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	knn_heap_if.sink   req,
	knn_heap_if.source rsp
);
	localparam int AW = (K > 1) ? $clog2(K) : 1;
	localparam int CW = $clog2(K + 1);
	localparam int PW = AW + 2;

	logic [DIST_W-1:0] heap_d_q [K];
	logic [ITEM_W-1:0] heap_i_q [K];
	logic [DIST_W:0]   work_d_q [K];
	logic [ITEM_W-1:0] work_i_q [K];
	logic [DIST_W:0]   sort_d_q [K];
	logic [ITEM_W-1:0] sort_i_q [K];

	state_t state_q, state_d;
	logic [PW-1:0]     pos_q;
	logic [CW-1:0]     cnt_q;
	logic [DIST_W:0]   key_q;
	logic [ITEM_W-1:0] kitem_q;
	logic              acc_q;
	rsp_t              out_q;
	logic              out_vld_q;

	// shared sift unit: one level
	logic [PW-1:0] l_pos, r_pos, pick;
	logic          has_l, has_r, do_swap;
	logic [DIST_W:0] lk, rk, pk;
	logic sift_heap;
	assign sift_heap = (state_q == ST_SIFT);
	assign l_pos = {pos_q[PW-2:0], 1'b1};
	assign r_pos = l_pos + PW'(1);
	assign has_l = l_pos < PW'(K);
	assign has_r = r_pos < PW'(K);

	always_comb begin
		lk = '0;
		rk = '0;
		if (has_l) lk = sift_heap ? {1'b0, heap_d_q[l_pos[AW-1:0]]} : work_d_q[l_pos[AW-1:0]];
		if (has_r) rk = sift_heap ? {1'b0, heap_d_q[r_pos[AW-1:0]]} : work_d_q[r_pos[AW-1:0]];
		pick = (!has_r || lk >= rk) ? l_pos : r_pos;
		pk = (!has_r || lk >= rk) ? lk : rk;
		do_swap = has_l && (pk > key_q);
	end

	logic out_free;
	logic out_load;
	assign out_free = !out_vld_q || rsp.ready;
	assign out_load = ((state_q == ST_REPLY) || (state_q == ST_DEMIT)) && out_free;
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_vld_q;
	assign rsp.payload = out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (req.valid) begin
				priority case (cmd_t'(req.payload.command))
					CMD_PUSH:  state_d = (req.payload.distance > heap_d_q[0]) ? ST_REPLY : ST_SIFT;
					CMD_DRAIN: state_d = ST_DCOPY;
					CMD_CLEAR: state_d = ST_CLEAR;
					default:   state_d = ST_IDLE;
				endcase
			end
			ST_SIFT:  if (!do_swap) state_d = ST_REPLY;
			ST_REPLY: if (out_free) state_d = ST_IDLE;
			ST_DCOPY: if (cnt_q == CW'(K - 1)) state_d = ST_DTAKE;
			ST_DTAKE: state_d = ST_DSIFT;
			ST_DSIFT: if (!do_swap) state_d = (cnt_q == '0) ? ST_DEMIT : ST_DTAKE;
			ST_DEMIT: if (out_free && cnt_q == CW'(K - 1)) state_d = ST_IDLE;
			ST_CLEAR: if (cnt_q == CW'(K - 1)) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_vld_q <= 1'b0;
			cnt_q <= '0;
			for (int i = 0; i < K; i++) begin
				heap_d_q[i] <= '1;
				heap_i_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_load) out_vld_q <= 1'b1;
			else if (rsp.ready) out_vld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					pos_q <= '0;
					acc_q <= 1'b0;
					key_q <= {1'b0, req.payload.distance};
					kitem_q <= req.payload.item_index;
					if (req.valid && req.payload.command == CMD_PUSH
						&& !(req.payload.distance > heap_d_q[0])) begin
						heap_d_q[0] <= req.payload.distance;
						heap_i_q[0] <= req.payload.item_index;
						acc_q <= 1'b1;
					end
				end
				ST_SIFT: if (do_swap) begin
					// advance: move child up, pushed entry down
					heap_d_q[pos_q[AW-1:0]] <= pk[DIST_W-1:0];
					heap_i_q[pos_q[AW-1:0]] <= heap_i_q[pick[AW-1:0]];
					heap_d_q[pick[AW-1:0]] <= key_q[DIST_W-1:0];
					heap_i_q[pick[AW-1:0]] <= kitem_q;
					pos_q <= pick;
				end
				ST_REPLY: if (out_free) begin
					out_q <= '{reply_kind: 1'b0, accepted: acc_q,
						out_distance: heap_d_q[0], out_index: '0, last: 1'b1};
				end
				ST_DCOPY: begin
					work_d_q[cnt_q[AW-1:0]] <= {1'b0, heap_d_q[cnt_q[AW-1:0]]} + (DIST_W+1)'(1);
					work_i_q[cnt_q[AW-1:0]] <= heap_i_q[cnt_q[AW-1:0]];
					cnt_q <= (cnt_q == CW'(K - 1)) ? cnt_q : cnt_q + CW'(1);
				end
				ST_DTAKE: begin
					sort_d_q[cnt_q[AW-1:0]] <= work_d_q[0];
					sort_i_q[cnt_q[AW-1:0]] <= work_i_q[0];
					work_d_q[0] <= '0;
					work_i_q[0] <= '0;
					key_q <= '0;
					kitem_q <= '0;
					pos_q <= '0;
				end
				ST_DSIFT: begin
					if (do_swap) begin
						work_d_q[pos_q[AW-1:0]] <= pk;
						work_i_q[pos_q[AW-1:0]] <= work_i_q[pick[AW-1:0]];
						work_d_q[pick[AW-1:0]] <= key_q;
						work_i_q[pick[AW-1:0]] <= kitem_q;
						pos_q <= pick;
					end else if (cnt_q != '0) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_DEMIT: if (out_free) begin
					out_q <= '{reply_kind: 1'b1, accepted: 1'b0,
						out_distance: (sort_d_q[cnt_q[AW-1:0]] == '0) ? '0 :
							DIST_W'(sort_d_q[cnt_q[AW-1:0]] - (DIST_W+1)'(1)),
						out_index: sort_i_q[cnt_q[AW-1:0]],
						last: (cnt_q == CW'(K - 1))};
					cnt_q <= cnt_q + CW'(1);
				end
				ST_CLEAR: begin
					heap_d_q[cnt_q[AW-1:0]] <= '1;
					heap_i_q[cnt_q[AW-1:0]] <= '0;
					cnt_q <= cnt_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req.ready) else $error("ready while busy");
	a_push_reply_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.payload.reply_kind) |-> rsp.payload.last)
		else $error("push reply without last");
	a_heap_root_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && K > 1) |-> heap_d_q[0] >= heap_d_q[K > 1 ? 1 : 0])
		else $error("root below child");
	a_sift_moves_down: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIFT && $past(state_q) == ST_SIFT) |-> pos_q != '0)
		else $error("sift position stuck at root");
endmodule
`default_nettype wire

// ===== dv/k_nearest_max_heap_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module k_nearest_max_heap_test;
	import knn_heap_pkg::*;

	localparam int K = 16;
	localparam int WATCHDOG_LIMIT = 20000;
	// Drain copies all K slots and then runs K take/sift passes; clear walks all K slots.
	localparam int SETTLE_CYCLES = 200;

	logic clk;
	logic arst_n;

	knn_heap_if #(.T(req_t)) req ();
	knn_heap_if #(.T(rsp_t)) rsp ();

	k_nearest_max_heap #(.K(K)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// Predictor state: the heap contents as the block should hold them.
	logic [DIST_W-1:0] heap_dist[K];
	logic [ITEM_W-1:0] heap_idx[K];

	req_t pending_requests[$];
	rsp_t expected_replies[$];

	int error_count = 0;
	int watchdog = 0;
	bit quiet_sender = 0;	// no idling on the request side
	bit quiet_receiver = 0;	// no idling on the reply side
	bit hold_replies = 0;	// long back-pressure stretch requested
	bit pause_sender = 0;	// sender waits for the reply queue to empty
	int hold_count = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sift (key, item) down from the root of a max-heap, larger child wins,
	// left child on a tie; swap only while the child is strictly greater.
	function automatic void sift_from_root(ref logic [DIST_W:0] keys[K],
			ref logic [ITEM_W-1:0] items[K], input logic [DIST_W:0] key,
			input logic [ITEM_W-1:0] item);
		int pos;
		int l;
		int pick;
		pos = 0;
		keys[0] = key;
		items[0] = item;
		forever begin
			l = 2 * pos + 1;
			if (l >= K)
				break;
			if (l + 1 >= K || keys[l] >= keys[l + 1])
				pick = l;
			else
				pick = l + 1;
			if (!(keys[pick] > key))
				break;
			keys[pos] = keys[pick];
			items[pos] = items[pick];
			keys[pick] = key;
			items[pick] = item;
			pos = pick;
		end
	endfunction

	function automatic void clear_heap();
		for (int i = 0; i < K; i++) begin
			heap_dist[i] = '1;
			heap_idx[i] = '0;
		end
	endfunction

	// Work out the replies one request causes and update the heap.
	function automatic void predict_replies(input req_t r);
		logic [DIST_W:0] keys[K];
		logic [ITEM_W-1:0] items[K];
		logic [DIST_W:0] sorted_key[K];
		logic [ITEM_W-1:0] sorted_idx[K];
		rsp_t e;
		case (cmd_t'(r.command))
			CMD_PUSH: begin
				e = '0;
				if (r.distance <= heap_dist[0]) begin
					for (int i = 0; i < K; i++) begin
						keys[i] = {1'b0, heap_dist[i]};
						items[i] = heap_idx[i];
					end
					sift_from_root(keys, items, {1'b0, r.distance}, r.item_index);
					for (int i = 0; i < K; i++) begin
						heap_dist[i] = keys[i][DIST_W-1:0];
						heap_idx[i] = items[i];
					end
					e.accepted = 1'b1;
				end
				e.out_distance = heap_dist[0];
				e.last = 1'b1;
				expected_replies.push_back(e);
			end
			CMD_DRAIN: begin
				// Keys held as distance+1 so that 0 sinks below everything.
				for (int i = 0; i < K; i++) begin
					keys[i] = {1'b0, heap_dist[i]} + 1'b1;
					items[i] = heap_idx[i];
				end
				for (int i = K - 1; i >= 0; i--) begin
					sorted_key[i] = keys[0];
					sorted_idx[i] = items[0];
					sift_from_root(keys, items, '0, '0);
				end
				for (int i = 0; i < K; i++) begin
					e = '0;
					e.reply_kind = 1'b1;
					e.out_distance = sorted_key[i] == 0 ? '0 :
						DIST_W'(sorted_key[i] - 1'b1);
					e.out_index = sorted_idx[i];
					e.last = (i == K - 1);
					expected_replies.push_back(e);
				end
			end
			CMD_CLEAR: clear_heap();
			default: ;
		endcase
	endfunction

	function automatic req_t make_req(cmd_t c, logic [ITEM_W-1:0] idx,
			logic [DIST_W-1:0] d);
		req_t r;
		r.command = c;
		r.item_index = idx;
		r.distance = d;
		return r;
	endfunction

	function automatic logic [DIST_W-1:0] rand_distance();
		case ($urandom_range(0, 9))
			0: return '1;
			1: return '0;
			2: return $urandom_range(0, 15);
			3: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// Driver: present the request at the head of the queue, advance on accept.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.payload <= '0;
		end else begin
			if (req.valid && req.ready) begin
				predict_replies(req.payload);
				void'(pending_requests.pop_front());
			end
			if (req.valid && !req.ready) begin
				// hold the request steady until it is taken
			end else if (pending_requests.size() > (req.valid && req.ready ? 0 : 0)
					&& !(pause_sender && expected_replies.size() != 0)
					&& (quiet_sender || $urandom_range(0, 99) >= 26)) begin
				req.valid <= 1'b1;
				req.payload <= pending_requests[0];
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Reply side: random stalls plus one long hold-off counted here.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold_count <= 0;
		end else if (hold_replies && hold_count < 300) begin
			hold_count <= hold_count + 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= quiet_receiver || $urandom_range(0, 99) >= 26;
		end
	end

	// Monitor: compare each reply field by field with the oldest expectation.
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_replies.size() == 0) begin
				$error("reply with nothing expected: %p", rsp.payload);
				error_count++;
			end else begin
				e = expected_replies.pop_front();
				if (rsp.payload.reply_kind !== e.reply_kind) begin
					$error("reply_kind exp %0d got %0d", e.reply_kind,
						rsp.payload.reply_kind);
					error_count++;
				end
				if (rsp.payload.accepted !== e.accepted) begin
					$error("accepted exp %0d got %0d", e.accepted, rsp.payload.accepted);
					error_count++;
				end
				if (rsp.payload.out_distance !== e.out_distance) begin
					$error("out_distance exp %h got %h", e.out_distance,
						rsp.payload.out_distance);
					error_count++;
				end
				if (rsp.payload.out_index !== e.out_index) begin
					$error("out_index exp %h got %h", e.out_index,
						rsp.payload.out_index);
					error_count++;
				end
				if (rsp.payload.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, rsp.payload.last);
					error_count++;
				end
			end
		end
	end

	// Watchdog: count cycles in which no request and no reply moves.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
		if (watchdog >= WATCHDOG_LIMIT) begin
			$display("k_nearest_max_heap_test: errors");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_requests.size() != 0 || req.valid || expected_replies.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int n;
		clear_heap();
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b0;
		#0.5 arst_n = 1'b1;

		// Directed: drain of the empty heap, boundary distances and indices,
		// equal-distance accept, rejection, clear, the unused command, drain.
		pending_requests.push_back(make_req(CMD_DRAIN, '0, '0));
		pending_requests.push_back(make_req(CMD_PUSH, '1, '1));
		pending_requests.push_back(make_req(CMD_PUSH, '0, '0));
		pending_requests.push_back(make_req(CMD_NONE, '1, '1));
		for (int i = 0; i < 14; i++)
			pending_requests.push_back(make_req(CMD_PUSH, ITEM_W'(i * 3 + 1),
				DIST_W'(100 - i * 5)));
		pending_requests.push_back(make_req(CMD_PUSH, 31'h5555_5555, 32'd100));
		pending_requests.push_back(make_req(CMD_PUSH, 31'h2AAA_AAAA, 32'hFFFF_FFFF));
		pending_requests.push_back(make_req(CMD_DRAIN, '0, '0));
		pending_requests.push_back(make_req(CMD_CLEAR, '0, '0));
		pending_requests.push_back(make_req(CMD_DRAIN, '0, '0));
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Long back-pressure while the sender keeps offering requests.
		hold_replies = 1;
		for (int i = 0; i < 40; i++)
			pending_requests.push_back(make_req(CMD_PUSH, ITEM_W'($urandom),
				rand_distance()));
		wait_drained();
		hold_replies = 0;

		// Random part: bursts of pushes between drains and occasional clears.
		n = 0;
		while (n < 300) begin
			cmd_t c;
			case ($urandom_range(0, 19))
				0: c = CMD_DRAIN;
				1: c = CMD_CLEAR;
				2: c = CMD_NONE;
				default: c = CMD_PUSH;
			endcase
			if (c != CMD_NONE)
				n++;
			pending_requests.push_back(make_req(c, ITEM_W'($urandom), rand_distance()));
			if (n == 100) begin
				quiet_sender = 1;
				quiet_receiver = 1;
			end
			if (n == 160) begin
				quiet_sender = 0;
				quiet_receiver = 0;
			end
			if (n % 50 == 0) begin
				// sender pauses until every expected reply is in
				pause_sender = 1;
				wait_drained();
				pause_sender = 0;
			end
		end
		pending_requests.push_back(make_req(CMD_DRAIN, '0, '0));
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("k_nearest_max_heap_test: clean");
		else
			$display("k_nearest_max_heap_test: errors");
		$finish;
	end
endmodule
`default_nettype wire
